// ===== hdl/olp_pkg.sv =====
package olp_pkg;

	// Field widths of one sample element and of one result.
	localparam int IDX_W  = 4;
	localparam int FEAT_W = 16;
	localparam int LR_W   = 12;

	// Weight, bias and accumulator widths (Q24.8 and Q40.16).
	localparam int W_W    = 32;
	localparam int SUM_W  = 56;
	localparam int FRAC_W = 8;

	// Product of the shared multiplier: weight (W_W) by feature (FEAT_W).
	localparam int PROD_W = W_W + FEAT_W;

	// Stream payload layout.
	localparam int IDX_LSB   = 0;
	localparam int FEAT_LSB  = IDX_LSB + IDX_W;
	localparam int LABEL_BIT = FEAT_LSB + FEAT_W;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 8;

	// Defaults.
	localparam int MAX_FEATURES_DEF = 16;
	localparam logic [LR_W-1:0] LR_RESET = LR_W'(256);

endpackage

// ===== hdl/online_perceptron_learner.sv =====
// Online binary perceptron with a fixed-point learning rule. A sample arrives as a run of
// stream transfers, one Q8.8 feature each, closed by tlast; the closing transfer also
// carries the command (tuser: 1 = train) and the label. Each feature is buffered and
// multiplied by its stored Q24.8 weight on one shared 32x16 multiplier, and the product is
// added into a saturating Q40.16 sum that starts at the bias. On the closing transfer one
// result goes out: the predicted class (sum >= 0 means +1) and a mistake flag. A training
// sample that was misclassified moves the bias by plus or minus learning_rate and then walks
// the weight memory once, adding the rounded product learning_rate * feature, signed by
// the label, to each weight whose feature was in the sample; weights and bias saturate at 32 bits.
// Timing: each feature passes through accept, weight read, multiply and accumulate, and the
// block is not ready in between. The closing transfer adds a decision step and a hand-off to
// the output register, which waits while an earlier result is held. A mistaken training
// sample adds an update pass over all MAX_FEATURES weights, each a read, a multiply and a
// write-back on the single-port weight memory and shared multiplier. Weights start at zero
// after reset with no clearing pass. learning_rate may be written only while the block is idle.
module online_perceptron_learner #(
	parameter int MAX_FEATURES = olp_pkg::MAX_FEATURES_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Fields from bit 0 up: feature_index[3:0], feature_value[19:4], label[20], zero fill.
	input  logic [olp_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic s_axis_tuser,  // command: 0 predict, 1 train
	input  logic s_axis_tlast,  // last_feature
	input  logic s_axis_tvalid,
	output logic s_axis_tready,

	// Fields from bit 0 up: predicted_class[0], mistake[1], zero fill.
	output logic [olp_pkg::M_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,

	// learning_rate, unsigned Q4.8.
	input  logic [olp_pkg::LR_W-1:0] cfg_data,
	input  logic cfg_valid,
	output logic cfg_ready
);

	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int XW = (AW > olp_pkg::IDX_W) ? AW : olp_pkg::IDX_W;
	localparam int W_W = olp_pkg::W_W;
	localparam int SUM_W = olp_pkg::SUM_W;
	localparam int PROD_W = olp_pkg::PROD_W;
	localparam int FEAT_W = olp_pkg::FEAT_W;
	localparam int FRAC_W = olp_pkg::FRAC_W;
	localparam int LR_W = olp_pkg::LR_W;
	localparam int DW = W_W + 2;  // weight plus step, before clamping

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WRD  = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_ACC  = 4'd3;
	localparam logic [3:0] ST_END  = 4'd4;
	localparam logic [3:0] ST_URD  = 4'd5;
	localparam logic [3:0] ST_UMUL = 4'd6;
	localparam logic [3:0] ST_UWR  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;

	// Configuration.
	logic [LR_W-1:0] lr_q;

	// Latched sample element.
	logic [AW-1:0] idx_q;
	logic signed [FEAT_W-1:0] feat_q;
	logic cmd_q, lbl_q, last_q;

	// Sample bookkeeping.
	logic open_q;
	logic [MAX_FEATURES-1:0] sval_q;   // feature present in the current sample
	logic [MAX_FEATURES-1:0] wset_q;   // weight entry written since reset

	// Storage.
	logic signed [W_W-1:0] w_mem [MAX_FEATURES];
	logic signed [FEAT_W-1:0] buf_mem [MAX_FEATURES];
	logic signed [W_W-1:0] w_rd_q;
	logic w_rv_q;
	logic signed [FEAT_W-1:0] buf_rd_q;

	logic signed [W_W-1:0] bias_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [AW-1:0] j_q;

	logic pred_q, mis_q;
	logic out_valid_q, out_pred_q, out_mis_q;

	// Input decode.
	logic in_acc;
	logic [olp_pkg::IDX_W-1:0] in_idx;
	logic [XW-1:0] in_idx_x;
	logic [AW-1:0] in_addr;
	logic in_range;
	logic signed [FEAT_W-1:0] in_feat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_idx = s_axis_tdata[olp_pkg::IDX_LSB +: olp_pkg::IDX_W];
	assign in_idx_x = XW'(in_idx);
	assign in_addr = in_idx_x[AW-1:0];
	assign in_range = (int'(in_idx) < MAX_FEATURES);
	assign in_feat = $signed(s_axis_tdata[olp_pkg::FEAT_LSB +: FEAT_W]);

	assign cfg_ready = 1'b1;

	// The weight memory is addressed by the update counter during the update pass and by
	// the latched feature index otherwise.
	logic upd;
	logic [AW-1:0] w_addr;
	logic signed [W_W-1:0] w_val;

	assign upd = (state_q == ST_URD) || (state_q == ST_UMUL) || (state_q == ST_UWR);
	assign w_addr = upd ? j_q : idx_q;
	assign w_val = w_rv_q ? w_rd_q : '0;

	// Shared multiplier: weight times feature, or learning rate times buffered feature.
	logic signed [W_W-1:0] mul_a;
	logic signed [FEAT_W-1:0] mul_b;

	assign mul_a = upd ? $signed({{(W_W-LR_W){1'b0}}, lr_q}) : w_val;
	assign mul_b = upd ? buf_rd_q : feat_q;

	// Saturating accumulate.
	logic signed [SUM_W:0] acc_x;
	logic signed [SUM_W-1:0] acc_sat;

	assign acc_x = (SUM_W+1)'(sum_q) + (SUM_W+1)'(prod_q);
	always_comb begin
		if (acc_x[SUM_W] != acc_x[SUM_W-1]) begin
			acc_sat = acc_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			acc_sat = acc_x[SUM_W-1:0];
		end
	end

	// Weight step: round the Q.16 product to Q.8 (nearest, ties up), sign from the label.
	logic signed [PROD_W-1:0] rnd_p;
	logic signed [DW-1:0] step, step_sgn, w_new_x;
	logic signed [W_W-1:0] w_new;

	assign rnd_p = prod_q + PROD_W'(1 << (FRAC_W - 1));
	assign step = DW'(rnd_p >>> FRAC_W);
	assign step_sgn = lbl_q ? step : -step;
	assign w_new_x = DW'(w_val) + step_sgn;
	always_comb begin
		if (w_new_x > DW'(32'sh7FFF_FFFF)) begin
			w_new = {1'b0, {(W_W-1){1'b1}}};
		end else if (w_new_x < -DW'(33'sh0_8000_0000)) begin
			w_new = {1'b1, {(W_W-1){1'b0}}};
		end else begin
			w_new = w_new_x[W_W-1:0];
		end
	end

	// Bias step.
	logic signed [W_W:0] b_step, b_new_x;
	logic signed [W_W-1:0] b_new;

	assign b_step = (W_W+1)'($signed({1'b0, lr_q}));
	assign b_new_x = lbl_q ? (W_W+1)'(bias_q) + b_step : (W_W+1)'(bias_q) - b_step;
	always_comb begin
		if (b_new_x[W_W] != b_new_x[W_W-1]) begin
			b_new = b_new_x[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
		end else begin
			b_new = b_new_x[W_W-1:0];
		end
	end

	// Decision on the closing element.
	logic pred_now, mis_now, w_we;

	assign pred_now = ~sum_q[SUM_W-1];
	assign mis_now = cmd_q && (pred_now != lbl_q);
	assign w_we = (state_q == ST_UWR) && sval_q[j_q];

	// Memories: written and read in clocked blocks, read data registered.
	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[j_q] <= w_new;
		end
		w_rd_q <= w_mem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_range) begin
			buf_mem[in_addr] <= in_feat;
		end
		buf_rd_q <= buf_mem[j_q];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q  <= in_addr;
			feat_q <= in_feat;
			cmd_q  <= s_axis_tuser;
			lbl_q  <= s_axis_tdata[olp_pkg::LABEL_BIT];
			last_q <= s_axis_tlast;
		end
		if ((state_q == ST_MUL) || (state_q == ST_UMUL)) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_END) begin
			pred_q <= pred_now;
			mis_q  <= mis_now;
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lr_q        <= olp_pkg::LR_RESET;
			open_q      <= 1'b0;
			sval_q      <= '0;
			wset_q      <= '0;
			w_rv_q      <= 1'b0;
			bias_q      <= '0;
			sum_q       <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			out_pred_q  <= 1'b0;
			out_mis_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lr_q <= cfg_data;
			end
			w_rv_q <= wset_q[w_addr];
			// In the output state the register is refilled by the state machine below.
			if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// The first element of a sample reloads the sum with the bias.
						if (!open_q) begin
							sum_q <= {{(SUM_W-W_W-FRAC_W){bias_q[W_W-1]}}, bias_q,
								{FRAC_W{1'b0}}};
						end
						open_q <= 1'b1;
						sval_q <= (open_q ? sval_q : '0) |
							(in_range ? (MAX_FEATURES'(1) << in_addr) : '0);
						if (in_range) begin
							state_q <= ST_WRD;
						end else if (s_axis_tlast) begin
							state_q <= ST_END;
						end
					end
				end
				ST_WRD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q <= acc_sat;
					state_q <= last_q ? ST_END : ST_IDLE;
				end
				ST_END: begin
					open_q <= 1'b0;
					j_q <= '0;
					if (mis_now) begin
						bias_q <= b_new;
						state_q <= ST_URD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_URD: begin
					state_q <= ST_UMUL;
				end
				ST_UMUL: begin
					state_q <= ST_UWR;
				end
				ST_UWR: begin
					if (w_we) begin
						wset_q[j_q] <= 1'b1;
					end
					if (j_q == AW'(MAX_FEATURES - 1)) begin
						state_q <= ST_OUT;
					end else begin
						j_q <= j_q + AW'(1);
						state_q <= ST_URD;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_pred_q  <= pred_q;
						out_mis_q   <= mis_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(olp_pkg::M_DATA_W-2){1'b0}}, out_mis_q, out_pred_q};

	// A new result is only ever loaded from the output state.
	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output state");

	// Weights are written only during the update pass.
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> (state_q == ST_UWR) && mis_q)
		else $error("weight written outside a mistaken training sample");

	// A correct prediction never starts an update pass.
	a_no_update_when_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && !mis_now) |=> (state_q == ST_OUT))
		else $error("update pass started without a mistake");

	// The bias moves only when a mistake is decided.
	a_bias_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bias_q) |-> $past(state_q == ST_END))
		else $error("bias changed outside the decision step");

endmodule
